/* rtl/core/square_tone_envelope_synth_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the square tone envelope synth
// Shared assertion forms, clocked on aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SQUARE_TONE_ENVELOPE_SYNTH_MACROS_SVH
`define SQUARE_TONE_ENVELOPE_SYNTH_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define STES_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// A condition that must be followed by another one on the next clock edge.
`define STES_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/core/stes_pkg.sv */
// ----------------------------------------------------------------------------
// Square tone envelope synth package
// Field widths, register codes, reset values and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stes_pkg;

    localparam int PHASE_BITS_DEF = 24;
    localparam int COUNT_BITS_DEF = 16;

    localparam int STEP_W   = 24;
    localparam int LEN_W    = 16;
    localparam int SAMPLE_W = 16;
    localparam int PEAK_W   = 15;
    localparam int DUTY_W   = 24;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_LEVEL    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FRACTION = 1'd1;

    localparam logic [PEAK_W-1:0] PEAK_RESET = 15'd6400;
    localparam logic [DUTY_W-1:0] DUTY_RESET = 24'd8388608;

    // The divider takes one peak level bit per step.
    localparam int ENV_STEPS = PEAK_W;
    localparam int ENV_CNT_W = $clog2(ENV_STEPS + 1);
    localparam int ENV_W     = 18;

    typedef struct packed {
        logic [STEP_W-1:0] phase_step;
        logic [LEN_W-1:0]  note_length;
        logic              note_start;
    } stes_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                       note_last;
    } stes_out_t;

    typedef struct packed {
        logic load;
        logic run;
    } stes_seq_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_DONE
    } stes_state_t;

endpackage

/* rtl/core/stes_phase_ser.sv */
// ----------------------------------------------------------------------------
// Bit-serial phase accumulator
// Adds the phase step one bit per cycle, LSB first, and compares the new
// phase with the duty fraction in the same pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stes_phase_ser #(
    parameter int PHASE_BITS = stes_pkg::PHASE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  stes_pkg::stes_seq_t   seq,
    input  logic                  clear,
    input  logic [PHASE_BITS-1:0] step_in,
    input  logic [PHASE_BITS-1:0] duty_in,
    output logic                  below_duty,
    output logic                  done
);

    localparam int CNT_W = $clog2(PHASE_BITS + 1);

    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [PHASE_BITS-1:0] step_reg, step_next;
    logic [PHASE_BITS-1:0] duty_reg, duty_next;
    logic                  carry_reg, carry_next;
    logic                  lt_reg, lt_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    logic sum_bit;

    assign done       = (cnt_reg == CNT_W'(PHASE_BITS));
    assign below_duty = lt_reg;
    assign sum_bit    = phase_reg[0] ^ step_reg[0] ^ carry_reg;

    always_comb begin
        phase_next = phase_reg;
        step_next  = step_reg;
        duty_next  = duty_reg;
        carry_next = carry_reg;
        lt_next    = lt_reg;
        cnt_next   = cnt_reg;
        if (seq.load) begin
            phase_next = clear ? '0 : phase_reg;
            step_next  = step_in;
            duty_next  = duty_in;
            carry_next = 1'b0;
            lt_next    = 1'b0;
            cnt_next   = '0;
        end else if (seq.run && !done) begin
            phase_next = {sum_bit, phase_reg[PHASE_BITS-1:1]};
            step_next  = {1'b0, step_reg[PHASE_BITS-1:1]};
            duty_next  = {1'b0, duty_reg[PHASE_BITS-1:1]};
            carry_next = (phase_reg[0] & step_reg[0]) |
                         (carry_reg & (phase_reg[0] ^ step_reg[0]));
            // A higher bit decides the comparison over all lower ones.
            lt_next    = (~sum_bit & duty_reg[0]) | (~(sum_bit ^ duty_reg[0]) & lt_reg);
            cnt_next   = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            carry_reg <= 1'b0;
            lt_reg    <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
            lt_reg    <= lt_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        duty_reg <= duty_next;
    end

endmodule

/* rtl/core/stes_env_div.sv */
// ----------------------------------------------------------------------------
// Digit-serial envelope scaler
// Computes floor(peak * m / d) for m < d, taking one peak level bit per
// cycle, MSB first, with a quotient digit of 0, 1 or 2 at each step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stes_env_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  stes_pkg::stes_seq_t           seq,
    input  logic [stes_pkg::PEAK_W-1:0]   peak_in,
    input  logic [stes_pkg::ENV_W-1:0]    m_in,
    input  logic [stes_pkg::ENV_W-1:0]    d_in,
    output logic [stes_pkg::PEAK_W-1:0]   mag,
    output logic                          done
);

    localparam int PW = stes_pkg::PEAK_W;
    localparam int EW = stes_pkg::ENV_W;
    localparam int TW = EW + 2;
    localparam int CW = stes_pkg::ENV_CNT_W;

    logic [PW-1:0] peak_reg, peak_next;
    logic [PW-1:0] q_reg, q_next;
    logic [EW-1:0] r_reg, r_next;
    logic [EW-1:0] m_reg, m_next;
    logic [EW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [TW-1:0] trial;
    logic [TW-1:0] d_one;
    logic [TW-1:0] d_two;
    logic [1:0]    digit;
    logic [EW-1:0] r_step;

    assign done  = (cnt_reg == CW'(stes_pkg::ENV_STEPS));
    assign mag   = q_reg;
    assign trial = {1'b0, r_reg, 1'b0} + (peak_reg[PW-1] ? TW'(m_reg) : '0);
    assign d_one = TW'(d_reg);
    assign d_two = {1'b0, d_reg, 1'b0};

    always_comb begin
        if (trial >= d_two) begin
            digit  = 2'd2;
            r_step = EW'(trial - d_two);
        end else if (trial >= d_one) begin
            digit  = 2'd1;
            r_step = EW'(trial - d_one);
        end else begin
            digit  = 2'd0;
            r_step = EW'(trial);
        end
    end

    always_comb begin
        peak_next = peak_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        m_next    = m_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        if (seq.load) begin
            peak_next = peak_in;
            q_next    = '0;
            r_next    = '0;
            m_next    = m_in;
            d_next    = d_in;
            cnt_next  = '0;
        end else if (seq.run && !done) begin
            peak_next = {peak_reg[PW-2:0], 1'b0};
            q_next    = {q_reg[PW-2:0], 1'b0} + PW'(digit);
            r_next    = r_step;
            cnt_next  = cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        peak_reg <= peak_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        m_reg    <= m_next;
        d_reg    <= d_next;
    end

endmodule

/* rtl/core/square_tone_envelope_synth.sv */
// ----------------------------------------------------------------------------
// Square tone envelope synth
// Square-wave tone generator with attack and release envelope, one output
// sample per input beat.
// ----------------------------------------------------------------------------
// One beat is taken at a time. The next beat is accepted only once the
// bit-serial phase adder, which handles one phase bit per cycle, and the
// 15-step envelope divider running beside it have both finished and the
// sample has moved into the output register. A finished sample waits in the
// output register while the next beat is accepted.
`timescale 1ns / 1ps

module square_tone_envelope_synth #(
    parameter int PHASE_BITS = stes_pkg::PHASE_BITS_DEF,
    parameter int COUNT_BITS = stes_pkg::COUNT_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  stes_pkg::stes_in_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output stes_pkg::stes_out_t               m_data,
    input  logic                              cfg_wr_en,
    input  logic [stes_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stes_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int LW  = stes_pkg::LEN_W;
    localparam int PW  = stes_pkg::PEAK_W;
    localparam int EW  = stes_pkg::ENV_W;
    localparam int SW  = stes_pkg::SAMPLE_W;
    localparam int SXW = (PHASE_BITS > stes_pkg::STEP_W) ? PHASE_BITS : stes_pkg::STEP_W;
    localparam int DXW = (PHASE_BITS > stes_pkg::DUTY_W) ? PHASE_BITS : stes_pkg::DUTY_W;
    localparam int KXW = (COUNT_BITS > LW) ? COUNT_BITS : LW;

    stes_pkg::stes_state_t state_reg, state_next;
    stes_pkg::stes_seq_t   seq;
    stes_pkg::stes_in_t    in_reg, in_next;
    stes_pkg::stes_out_t   out_reg, out_next;

    logic                  out_load;
    logic                  m_valid_reg, m_valid_next;
    logic [PW-1:0]         peak_reg, peak_next;
    logic [stes_pkg::DUTY_W-1:0] duty_reg, duty_next;
    logic [COUNT_BITS-1:0] index_reg, index_next;
    logic                  sound_reg, sound_next;
    logic                  last_reg, last_next;
    logic                  shaped_reg, shaped_next;

    logic [SXW-1:0]        step_x;
    logic [DXW-1:0]        duty_x;
    logic [PHASE_BITS-1:0] step_p;
    logic [PHASE_BITS-1:0] duty_p;
    logic [COUNT_BITS-1:0] k_cur;
    logic [KXW-1:0]        k_x;
    logic [KXW-1:0]        len_x;
    logic [LW-1:0]         k16;
    logic                  in_range;
    logic                  attack;
    logic                  release_ph;
    logic [20:0]           k25;
    logic [19:0]           k10;
    logic [19:0]           len7;
    logic [19:0]           rem10;
    logic [EW-1:0]         len3;
    logic [EW-1:0]         env_m;
    logic [EW-1:0]         env_d;

    logic                  below_duty;
    logic                  phase_done;
    logic [PW-1:0]         env_mag;
    logic                  env_done;
    logic [PW-1:0]         mag_sel;
    logic signed [SW-1:0]  mag_s;

    assign step_x = SXW'(in_reg.phase_step);
    assign step_p = step_x[PHASE_BITS-1:0];
    assign duty_x = DXW'(duty_reg);
    assign duty_p = duty_x[PHASE_BITS-1:0];

    assign k_cur    = in_reg.note_start ? '0 : index_reg;
    assign k_x      = KXW'(k_cur);
    assign len_x    = KXW'(in_reg.note_length);
    assign in_range = (k_x < len_x);
    assign k16      = k_x[LW-1:0];

    assign k25        = 21'(k16) * 21'd25;
    assign k10        = 20'(k16) * 20'd10;
    assign len7       = 20'(in_reg.note_length) * 20'd7;
    assign rem10      = 20'(in_reg.note_length - k16) * 20'd10;
    assign len3       = EW'(in_reg.note_length) * EW'(3);
    assign attack     = (k25 < 21'(in_reg.note_length));
    assign release_ph = (k10 > len7);
    assign env_m      = attack ? EW'(k25) : EW'(rem10);
    assign env_d      = attack ? EW'(in_reg.note_length) : len3;

    stes_phase_ser #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .seq        (seq),
        .clear      (in_reg.note_start),
        .step_in    (in_range ? step_p : '0),
        .duty_in    (duty_p),
        .below_duty (below_duty),
        .done       (phase_done)
    );

    stes_env_div u_env (
        .aclk    (aclk),
        .aresetn (aresetn),
        .seq     (seq),
        .peak_in (peak_reg),
        .m_in    (env_m),
        .d_in    (env_d),
        .mag     (env_mag),
        .done    (env_done)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stes_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = stes_pkg::ST_SETUP;
                end
            end
            stes_pkg::ST_SETUP: begin
                state_next = stes_pkg::ST_RUN;
            end
            stes_pkg::ST_RUN: begin
                if (phase_done && env_done) begin
                    state_next = stes_pkg::ST_DONE;
                end
            end
            stes_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = stes_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        seq.load = 1'b0;
        seq.run  = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            stes_pkg::ST_IDLE:  s_ready  = 1'b1;
            stes_pkg::ST_SETUP: seq.load = 1'b1;
            stes_pkg::ST_RUN:   seq.run  = 1'b1;
            stes_pkg::ST_DONE:  out_load = !m_valid_reg || m_ready;
        endcase
    end

    always_comb begin
        peak_next = peak_reg;
        duty_next = duty_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                stes_pkg::CFG_PEAK_LEVEL:    peak_next = cfg_data[PW-1:0];
                stes_pkg::CFG_DUTY_FRACTION: duty_next = cfg_data[stes_pkg::DUTY_W-1:0];
            endcase
        end
    end

    always_comb begin
        in_next     = in_reg;
        index_next  = index_reg;
        sound_next  = sound_reg;
        last_next   = last_reg;
        shaped_next = shaped_reg;
        if (s_valid && s_ready) begin
            in_next = s_data;
        end
        if (seq.load) begin
            index_next  = (in_range && (k_cur != '1)) ? k_cur + COUNT_BITS'(1) : k_cur;
            sound_next  = in_range && (step_p != '0);
            last_next   = in_range && (k_x == len_x - KXW'(1));
            shaped_next = attack || release_ph;
        end
    end

    assign mag_sel = shaped_reg ? env_mag : peak_reg;
    assign mag_s   = signed'({1'b0, mag_sel});

    always_comb begin
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (out_load) begin
            out_next.note_last    = last_reg;
            out_next.sample_value = sound_reg ? (below_duty ? mag_s : -mag_s) : '0;
            m_valid_next          = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= stes_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            peak_reg    <= stes_pkg::PEAK_RESET;
            duty_reg    <= stes_pkg::DUTY_RESET;
            index_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            peak_reg    <= peak_next;
            duty_reg    <= duty_next;
            index_reg   <= index_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        out_reg    <= out_next;
        sound_reg  <= sound_next;
        last_reg   <= last_next;
        shaped_reg <= shaped_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

/* rtl/core/stes_checker.sv */
// ----------------------------------------------------------------------------
// Square tone envelope synth checker
// Port-level assertions on beat order and sample range, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "square_tone_envelope_synth_macros.svh"

module stes_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input stes_pkg::stes_out_t m_data
);

    // The envelope magnitude never exceeds 15 bits, so the most negative code
    // cannot appear.
    `STES_ASSERT(a_no_min_code, m_valid |-> (m_data.sample_value != 16'sh8000), "Sample out of range.")

    // Only one input beat is in work at a time.
    `STES_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "Second beat taken too early.")

    // A result cannot be ready on the cycle right after its beat was taken.
    `STES_ASSERT_NEXT(a_no_instant_result, s_valid && s_ready && !m_valid, !m_valid, "Result appeared too early.")

    // A stalled result beat holds its value.
    `STES_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "Stalled result changed.")

endmodule

bind square_tone_envelope_synth stes_checker u_stes_checker (.*);
